// ===== src/vfd_pkg.sv =====
`timescale 1ns / 1ps

package vfd_pkg;

   localparam int LEN_W = 24;
   localparam int ACC_W = 34;
   localparam int CNT_W = 24;
   localparam int MAX_RESULTS = 3;
   localparam int RES_CNT_W = $clog2(MAX_RESULTS + 1);

   localparam int DEFAULT_MAX_HEADER_DIGITS = 10;
   localparam logic [LEN_W-1:0] DEFAULT_MAX_FRAME_LEN = 24'd1048576;

   localparam logic [7:0] MARKER_LEAD = 8'hFF;
   localparam logic [7:0] MARKER_EOI = 8'hD9;
   localparam logic [7:0] MARKER_SOI = 8'hD8;
   localparam logic [7:0] ASCII_ZERO = 8'h30;
   localparam logic [7:0] ASCII_NINE = 8'h39;

   localparam logic FMT_RAW = 1'b0;
   localparam logic FMT_LEN = 1'b1;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_RAW,
      MODE_HDR,
      MODE_DATA,
      MODE_SKIP
   } mode_type;

   typedef enum logic [2:0] {
      ST_DATA = 3'd0,
      ST_CLOSED = 3'd1,
      ST_ZERO_LEN = 3'd2,
      ST_TOO_LARGE = 3'd3,
      ST_INCOMPLETE = 3'd4,
      ST_UNKNOWN = 3'd5,
      ST_END_IDLE = 3'd6
   } status_type;

   typedef struct packed {
      status_type status;
      logic [7:0] data;
      logic frame_end;
      logic frame_format;
      logic [CNT_W-1:0] frames_done;
   } result_type;

endpackage

// ===== src/video_frame_deframer.sv =====
`timescale 1ns / 1ps

// Splits a byte stream into frames, one input beat per clock while req_ready is high. A frame
// that starts with 0xFF is passed through as raw MJPEG; one that starts with a decimal digit
// carries a length header of up to MAX_HEADER_DIGITS digits followed by that many data bytes.
// Errors come out as single status beats. Each input beat yields zero to three result beats,
// which go into a three-entry result buffer that drains one beat per clock while rsp_ready is
// high. A new input beat is taken whenever that buffer is empty or its last beat leaves in the
// same cycle, so the block sustains one input beat per cycle while each beat yields at most one
// result and rsp_ready is high; more results stall the input until one is left. The frame limit
// is written through csr_wr_en and csr_wr_data and must only change while the block is idle.
module video_frame_deframer
   import vfd_pkg::*;
#(
   parameter int MAX_HEADER_DIGITS = DEFAULT_MAX_HEADER_DIGITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [LEN_W-1:0] csr_wr_data,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_kind,
   input  logic [7:0]       req_in_byte,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_frame_end,
   output logic             rsp_frame_format,
   output logic [CNT_W-1:0] rsp_frames_done,
   output logic             rsp_run_last
);

   localparam int DC_W = $clog2(MAX_HEADER_DIGITS + 1);

   typedef struct packed {
      mode_type md;
      logic [LEN_W-1:0] bi;
      logic [ACC_W-1:0] la;
      logic [DC_W-1:0] dc;
      logic [7:0] ps;
      logic [1:0] hb;
      logic [CNT_W-1:0] fc;
   } state_type;

   typedef struct packed {
      state_type s;
      logic [RES_CNT_W-1:0] n;
      result_type [MAX_RESULTS-1:0] r;
      logic ended;
   } ctx_type;

   function automatic ctx_type f_put(ctx_type c, status_type st, logic [7:0] b, logic e,
                                     logic f);
      if (c.n < RES_CNT_W'(MAX_RESULTS)) begin
         if (e) begin
            c.s.fc = c.s.fc + 1'b1;
         end
         c.r[c.n].status = st;
         c.r[c.n].data = b;
         c.r[c.n].frame_end = e;
         c.r[c.n].frame_format = f;
         c.r[c.n].frames_done = c.s.fc;
         c.n = c.n + 1'b1;
      end
      return c;
   endfunction

   function automatic ctx_type f_raw_store(ctx_type c, logic [7:0] b, logic force_end,
                                           logic [LEN_W-1:0] lim);
      logic e;
      c.s.bi = c.s.bi + 1'b1;
      c.s.ps = b;
      e = force_end || (c.s.bi >= lim);
      c = f_put(c, ST_DATA, b, e, FMT_RAW);
      if (e) begin
         c.s.md = MODE_IDLE;
         c.s.hb = 2'd0;
      end
      c.ended = e;
      return c;
   endfunction

   function automatic ctx_type f_header_done(ctx_type c, logic [LEN_W-1:0] lim);
      c.s.dc = '0;
      if (c.s.la == '0) begin
         c = f_put(c, ST_ZERO_LEN, 8'd0, 1'b0, FMT_LEN);
         c.s.md = MODE_IDLE;
      end else if (c.s.la > ACC_W'(lim)) begin
         c = f_put(c, ST_TOO_LARGE, 8'd0, 1'b0, FMT_LEN);
         c.s.md = MODE_SKIP;
      end else begin
         c.s.md = MODE_DATA;
      end
      return c;
   endfunction

   function automatic logic f_is_digit(logic [7:0] b);
      return (b >= ASCII_ZERO) && (b <= ASCII_NINE);
   endfunction

   function automatic ctx_type f_idle_byte(ctx_type c, logic [7:0] b, logic [LEN_W-1:0] lim);
      if (b == MARKER_LEAD) begin
         c.s.md = MODE_RAW;
         c.s.bi = '0;
         c.s.hb = 2'd0;
         c = f_raw_store(c, b, 1'b0, lim);
      end else if (f_is_digit(b)) begin
         c.s.md = MODE_HDR;
         c.s.la = ACC_W'(b[3:0]);
         c.s.dc = DC_W'(1);
         if (c.s.dc >= DC_W'(MAX_HEADER_DIGITS)) begin
            c = f_header_done(c, lim);
         end
      end else begin
         c = f_put(c, ST_UNKNOWN, 8'd0, 1'b0, FMT_RAW);
      end
      return c;
   endfunction

   function automatic ctx_type f_raw_or_idle(ctx_type c, logic [7:0] b,
                                             logic [LEN_W-1:0] lim);
      if (c.s.md == MODE_RAW) begin
         c = f_raw_store(c, b, 1'b0, lim);
      end else begin
         c = f_idle_byte(c, b, lim);
      end
      return c;
   endfunction

   function automatic ctx_type f_data_byte(ctx_type c, logic [7:0] b);
      logic e;
      c.s.la = c.s.la - 1'b1;
      e = (c.s.la == '0);
      c = f_put(c, ST_DATA, b, e, FMT_LEN);
      if (e) begin
         c.s.md = MODE_IDLE;
      end
      return c;
   endfunction

   function automatic ctx_type f_skip_byte(ctx_type c);
      c.s.la = c.s.la - 1'b1;
      if (c.s.la == '0) begin
         c.s.md = MODE_IDLE;
      end
      return c;
   endfunction

   function automatic ctx_type f_raw_byte(ctx_type c, logic [7:0] b, logic [LEN_W-1:0] lim);
      if (c.s.hb == 2'd0) begin
         if ((c.s.bi >= LEN_W'(2)) && (c.s.ps == MARKER_LEAD) && (b == MARKER_EOI) &&
             (({1'b0, c.s.bi} + 1'b1) < {1'b0, lim})) begin
            c.s.hb = 2'd1;
         end else begin
            c = f_raw_store(c, b, 1'b0, lim);
         end
      end else if (c.s.hb == 2'd1) begin
         if (b == MARKER_LEAD) begin
            c.s.hb = 2'd2;
         end else begin
            c.s.hb = 2'd0;
            c = f_raw_store(c, MARKER_EOI, 1'b0, lim);
            if (c.ended) begin
               c = f_idle_byte(c, b, lim);
            end else begin
               c = f_raw_store(c, b, 1'b0, lim);
            end
         end
      end else begin
         c.s.hb = 2'd0;
         if (b == MARKER_SOI) begin
            c = f_raw_store(c, MARKER_EOI, 1'b1, lim);
            c = f_idle_byte(c, MARKER_LEAD, lim);
            c = f_raw_or_idle(c, b, lim);
         end else begin
            c = f_raw_store(c, MARKER_EOI, 1'b0, lim);
            if (c.ended) begin
               c = f_idle_byte(c, MARKER_LEAD, lim);
               c = f_raw_or_idle(c, b, lim);
            end else begin
               c = f_raw_store(c, MARKER_LEAD, 1'b0, lim);
               if (c.ended) begin
                  c = f_idle_byte(c, b, lim);
               end else begin
                  c = f_raw_store(c, b, 1'b0, lim);
               end
            end
         end
      end
      return c;
   endfunction

   function automatic ctx_type f_header_byte(ctx_type c, logic [7:0] b,
                                             logic [LEN_W-1:0] lim);
      if (f_is_digit(b) && (c.s.dc < DC_W'(MAX_HEADER_DIGITS))) begin
         c.s.la = (c.s.la << 3) + (c.s.la << 1) + ACC_W'(b[3:0]);
         c.s.dc = c.s.dc + 1'b1;
         if (c.s.dc >= DC_W'(MAX_HEADER_DIGITS)) begin
            c = f_header_done(c, lim);
         end
      end else begin
         c = f_header_done(c, lim);
         if (c.s.md == MODE_DATA) begin
            c = f_data_byte(c, b);
         end else if (c.s.md == MODE_SKIP) begin
            c = f_skip_byte(c);
         end else begin
            c = f_idle_byte(c, b, lim);
         end
      end
      return c;
   endfunction

   function automatic ctx_type f_end_of_stream(ctx_type c, logic [LEN_W-1:0] lim);
      logic [1:0] h;
      if (c.s.md == MODE_RAW) begin
         h = c.s.hb;
         c.s.hb = 2'd0;
         if (h != 2'd0) begin
            c = f_raw_store(c, MARKER_EOI, 1'b0, lim);
            if (h == 2'd2) begin
               if (c.ended) begin
                  c = f_idle_byte(c, MARKER_LEAD, lim);
               end else begin
                  c = f_raw_store(c, MARKER_LEAD, 1'b0, lim);
               end
            end
         end
         if (c.s.md == MODE_RAW) begin
            c = f_put(c, ST_CLOSED, 8'd0, 1'b1, FMT_RAW);
         end else begin
            c = f_put(c, ST_END_IDLE, 8'd0, 1'b0, FMT_RAW);
         end
      end else begin
         if (c.s.md == MODE_HDR) begin
            c = f_header_done(c, lim);
         end
         if (c.s.md == MODE_DATA) begin
            c = f_put(c, ST_INCOMPLETE, 8'd0, 1'b0, FMT_LEN);
         end else begin
            c = f_put(c, ST_END_IDLE, 8'd0, 1'b0, FMT_RAW);
         end
      end
      c.s.md = MODE_IDLE;
      c.s.bi = '0;
      c.s.la = '0;
      c.s.dc = '0;
      c.s.hb = 2'd0;
      return c;
   endfunction

   logic [LEN_W-1:0] max_len_ff;
   logic [LEN_W-1:0] limit;
   state_type state_ff;
   ctx_type step;
   result_type [MAX_RESULTS-1:0] res_ff;
   result_type [MAX_RESULTS-1:0] res_in;
   logic [RES_CNT_W-1:0] cnt_ff;
   logic [RES_CNT_W-1:0] cnt_in;
   logic req_fire;
   logic rsp_fire;

   assign limit = (max_len_ff == '0) ? LEN_W'(1) : max_len_ff;

   always_comb begin
      step = '0;
      step.s = state_ff;
      if (req_kind) begin
         step = f_end_of_stream(step, limit);
      end else begin
         unique case (state_ff.md)
            MODE_RAW: begin
               step = f_raw_byte(step, req_in_byte, limit);
            end
            MODE_HDR: begin
               step = f_header_byte(step, req_in_byte, limit);
            end
            MODE_DATA: begin
               step = f_data_byte(step, req_in_byte);
            end
            MODE_SKIP: begin
               step = f_skip_byte(step);
            end
            default: begin
               step.s.md = MODE_IDLE;
               step = f_idle_byte(step, req_in_byte, limit);
            end
         endcase
      end
   end

   assign rsp_valid = (cnt_ff != '0);
   assign rsp_fire = rsp_valid && rsp_ready;
   assign req_ready = (cnt_ff == '0) || ((cnt_ff == RES_CNT_W'(1)) && rsp_ready);
   assign req_fire = req_valid && req_ready;

   always_comb begin
      res_in = res_ff;
      cnt_in = cnt_ff;
      if (req_fire) begin
         res_in = step.r;
         cnt_in = step.n;
      end else if (rsp_fire) begin
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            res_in[i] = res_ff[i+1];
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= DEFAULT_MAX_FRAME_LEN;
         state_ff <= '{md: MODE_IDLE, default: '0};
         cnt_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
         if (req_fire) begin
            state_ff <= step.s;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_status = res_ff[0].status;
   assign rsp_out_byte = res_ff[0].data;
   assign rsp_frame_end = res_ff[0].frame_end;
   assign rsp_frame_format = res_ff[0].frame_format;
   assign rsp_frames_done = res_ff[0].frames_done;
   assign rsp_run_last = (cnt_ff == RES_CNT_W'(1));

endmodule
